>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SVN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SVN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/svn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package svn_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned SensW  = 16;
  localparam int unsigned ScaleW = 32;
  localparam int unsigned SumW   = 32;
  localparam int unsigned RootW  = 24;
  localparam int unsigned RremW  = 48;
  localparam int unsigned UnitW  = 15;
  localparam int unsigned UremW  = 59;
  localparam int unsigned ProdW  = 47;
  localparam int unsigned OutUW  = 16;
  localparam int unsigned Axes   = 3;
  localparam int unsigned UnitFrac = 28;

  localparam logic [SensW-1:0] SensReset = 16'd3998;

  typedef struct packed {
    logic [Axes-1:0][ScaleW-1:0] scaled;
    logic [Axes-1:0]             neg;
    logic                        zero;
    logic [SumW-1:0]             sum;
    logic [RremW-1:0]            rrem;
    logic [RootW-1:0]            root;
    logic [Axes-1:0][UremW-1:0]  urem;
    logic [Axes-1:0][ProdW-1:0]  prod;
    logic [Axes-1:0][UnitW-1:0]  uq;
  } stage_t;

endpackage
`default_nettype wire

>>> rtl/core/sensor_vector_scale_normalize_top.sv
`timescale 1ns / 1ps
// A beat passes the front registers, the root steps and the output register.
// Throughput: one beat per cycle; the 24 root steps run as one pipeline stage each,
// the 15 unit steps share the first 15 of them, and the whole pipe holds while the
// output is stalled.
// Reset: rst_ni is asynchronous and active low; it empties the pipe and
// sets the sensitivity register to 3998.
`default_nettype none
`include "assert_macros.svh"
module sensor_vector_scale_normalize_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // x_raw, y_raw, z_raw
  input  wire logic [47:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // x_scaled, y_scaled, z_scaled, magnitude, x_unit, y_unit, z_unit
  output logic [175:0]      m_axis_tdata,
  // zero_vector
  output logic [0:0]        m_axis_tuser
);

  localparam int unsigned Steps = svn_pkg::RootW;

  logic [svn_pkg::SensW-1:0] sens_q;
  logic                      adv;
  logic [Steps:0]            vld;
  svn_pkg::stage_t           stg [Steps+1];
  logic                      out_vld_q;
  logic [175:0]              out_data_d, out_data_q;
  logic                      out_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= svn_pkg::SensReset;
    end else if (cfg_we_i) begin
      sens_q <= cfg_wdata_i;
    end
  end

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  svn_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (s_axis_tvalid),
    .raw_i   (s_axis_tdata),
    .sens_i  (sens_q),
    .vld_o   (vld[0]),
    .stage_o (stg[0])
  );

  for (genvar k = 0; k < Steps; k++) begin : g_step
    svn_step #(.Stage(k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .vld_i   (vld[k]),
      .stage_i (stg[k]),
      .vld_o   (vld[k+1]),
      .stage_o (stg[k+1])
    );
  end

  always_comb begin
    logic [39:0]               mp;
    logic [svn_pkg::OutUW-1:0] u;
    mp = stg[Steps].root * sens_q;
    out_data_d[95:0]   = stg[Steps].scaled;
    out_data_d[127:96] = mp[39:8];
    for (int i = 0; i < svn_pkg::Axes; i++) begin
      u = {1'b0, stg[Steps].uq[i]};
      if (stg[Steps].zero) begin
        u = '0;
      end else if (stg[Steps].neg[i]) begin
        u = -u;
      end
      out_data_d[128 + 16*i +: 16] = u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_zero_q <= stg[Steps].zero;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_zero_q;

  `SVN_ASSERT_NOW(a_zero_out, clk_i, rst_ni, out_vld_q && out_zero_q,
    out_data_q[175:96] == '0)
  `SVN_ASSERT_NOW(a_unit_range, clk_i, rst_ni, vld[Steps] && !stg[Steps].zero,
    stg[Steps].uq[0] <= 15'd16384 && stg[Steps].uq[1] <= 15'd16384 &&
    stg[Steps].uq[2] <= 15'd16384)
  `SVN_ASSERT_NXT(a_hold_last, clk_i, rst_ni, vld[Steps] && !adv, vld[Steps])

endmodule
`default_nettype wire

>>> rtl/core/svn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module svn_front (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          adv_i,
  input  wire logic                                          vld_i,
  input  wire logic [svn_pkg::Axes-1:0][svn_pkg::RawW-1:0]   raw_i,
  input  wire logic [svn_pkg::SensW-1:0]                     sens_i,
  output logic                                               vld_o,
  output svn_pkg::stage_t                                    stage_o
);

  logic                                             vld1_q;
  logic [svn_pkg::Axes-1:0][svn_pkg::ScaleW-1:0]    scaled_d, scaled_q;
  logic [svn_pkg::Axes-1:0][svn_pkg::SumW-1:0]      sq_d, sq_q;
  logic [svn_pkg::Axes-1:0]                         neg_q;
  logic                                             vld2_q;
  svn_pkg::stage_t                                  stage_d, stage_q;

  always_comb begin
    logic signed [svn_pkg::RawW-1:0]   c;
    logic signed [svn_pkg::ScaleW:0]   p;
    logic signed [svn_pkg::SumW-1:0]   s;
    for (int i = 0; i < svn_pkg::Axes; i++) begin
      c = $signed(raw_i[i]);
      p = c * $signed({1'b0, sens_i});
      s = c * c;
      scaled_d[i] = p[svn_pkg::ScaleW-1:0];
      sq_d[i] = $unsigned(s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      scaled_q <= scaled_d;
      sq_q     <= sq_d;
      for (int i = 0; i < svn_pkg::Axes; i++) begin
        neg_q[i] <= raw_i[i][svn_pkg::RawW-1];
      end
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_d        = '0;
    stage_d.scaled = scaled_q;
    stage_d.neg    = neg_q;
    stage_d.sum    = sq_q[0] + sq_q[1] + sq_q[2];
    stage_d.zero   = (stage_d.sum == '0);
    stage_d.rrem   = {stage_d.sum, 16'd0};
    for (int i = 0; i < svn_pkg::Axes; i++) begin
      stage_d.urem[i] = svn_pkg::UremW'(sq_q[i]) << svn_pkg::UnitFrac;
    end
  end

  assign vld_o   = vld2_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

>>> rtl/core/svn_step.sv
`timescale 1ns / 1ps
`default_nettype none
module svn_step #(
  parameter int unsigned Stage = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             vld_i,
  input  svn_pkg::stage_t       stage_i,
  output logic                  vld_o,
  output svn_pkg::stage_t       stage_o
);

  localparam int unsigned RootBit = svn_pkg::RootW - 1 - Stage;
  localparam bit          UnitOn  = (Stage < svn_pkg::UnitW);
  localparam int unsigned UnitBit = UnitOn ? (svn_pkg::UnitW - 1 - Stage) : 0;
  localparam int unsigned RtW     = svn_pkg::RremW + 2;
  localparam int unsigned UtW     = 64;

  logic            vld_q;
  svn_pkg::stage_t stage_d, stage_q;

  always_comb begin
    logic [RtW-1:0] rt;
    logic [UtW-1:0] ut;
    stage_d = stage_i;
    rt = (RtW'(stage_i.root) << (RootBit + 1)) + (RtW'(1) << (2 * RootBit));
    if (RtW'(stage_i.rrem) >= rt) begin
      stage_d.rrem = stage_i.rrem - rt[svn_pkg::RremW-1:0];
      stage_d.root = stage_i.root | (svn_pkg::RootW'(1) << RootBit);
    end
    if (UnitOn) begin
      for (int i = 0; i < svn_pkg::Axes; i++) begin
        ut = (UtW'(stage_i.prod[i]) << (UnitBit + 1)) +
             (UtW'(stage_i.sum) << (2 * UnitBit));
        if (UtW'(stage_i.urem[i]) >= ut) begin
          stage_d.urem[i] = stage_i.urem[i] - ut[svn_pkg::UremW-1:0];
          stage_d.prod[i] = stage_i.prod[i] + (svn_pkg::ProdW'(stage_i.sum) << UnitBit);
          stage_d.uq[i]   = stage_i.uq[i] | (svn_pkg::UnitW'(1) << UnitBit);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign vld_o   = vld_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [15:0] z_unit;
    logic [15:0] y_unit;
    logic [15:0] x_unit;
    logic [31:0] magnitude;
    logic [31:0] z_scaled;
    logic [31:0] y_scaled;
    logic [31:0] x_scaled;
    logic        zero_vector;
  } vec_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [15:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [175:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  logic [15:0]  sens_shadow = 16'd3998;
  vec_result_t  expected_q[$];
  int           mismatches = 0;
  int           beats_sent = 0;
  int           beats_seen = 0;
  int           zero_vectors_seen = 0;
  bit           quiet_mode = 1'b0;

  sensor_vector_scale_normalize_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_component(logic signed [15:0] c, logic [63:0] s);
    logic [63:0] ac;
    logic [63:0] q;
    logic signed [16:0] v;
    if (s == 0) return 16'd0;
    ac = c < 0 ? 64'(-int'(c)) : 64'(int'(c));
    q = root_floor(((ac * ac) << 28) / s);
    if (q > 16384) q = 16384;
    v = c < 0 ? -$signed({1'b0, q[15:0]}) : $signed({1'b0, q[15:0]});
    return v[15:0];
  endfunction

  function automatic vec_result_t predict_vector(logic [47:0] raw);
    vec_result_t r;
    logic signed [15:0] x, y, z;
    logic [63:0] s;
    logic [63:0] root;
    x = raw[15:0];
    y = raw[31:16];
    z = raw[47:32];
    s = 64'(int'(x) * int'(x)) + 64'(int'(y) * int'(y)) + 64'(int'(z) * int'(z));
    root = root_floor(s << 16);
    r.x_scaled = 32'(64'(x) * $signed({1'b0, sens_shadow}));
    r.y_scaled = 32'(64'(y) * $signed({1'b0, sens_shadow}));
    r.z_scaled = 32'(64'(z) * $signed({1'b0, sens_shadow}));
    r.magnitude = 32'((root * sens_shadow) >> 8);
    r.x_unit = unit_component(x, s);
    r.y_unit = unit_component(y, s);
    r.z_unit = unit_component(z, s);
    r.zero_vector = (s == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch in %s at beat %0d: got %h, expected %h", what, beats_seen, got, want);
  endtask

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (!quiet_mode && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    expected_q.push_back(predict_vector({z, y, x}));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_sensitivity(logic [15:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sens_shadow = value;
  endtask

  task automatic send_random_sample();
    logic [15:0] v[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(5))
        0: v[i] = 16'h8000;
        1: v[i] = 16'h7FFF;
        2: v[i] = 16'(int'($urandom_range(8)) - 4);
        default: v[i] = 16'($urandom);
      endcase
    end
    send_sample(v[0], v[1], v[2]);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    vec_result_t got;
    vec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser[0]};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.x_scaled !== want.x_scaled) report_mismatch("x_scaled", got.x_scaled, want.x_scaled);
        if (got.y_scaled !== want.y_scaled) report_mismatch("y_scaled", got.y_scaled, want.y_scaled);
        if (got.z_scaled !== want.z_scaled) report_mismatch("z_scaled", got.z_scaled, want.z_scaled);
        if (got.magnitude !== want.magnitude) begin
          report_mismatch("magnitude", got.magnitude, want.magnitude);
        end
        if (got.x_unit !== want.x_unit) begin
          report_mismatch("x_unit", 32'(got.x_unit), 32'(want.x_unit));
        end
        if (got.y_unit !== want.y_unit) begin
          report_mismatch("y_unit", 32'(got.y_unit), 32'(want.y_unit));
        end
        if (got.z_unit !== want.z_unit) begin
          report_mismatch("z_unit", 32'(got.z_unit), 32'(want.z_unit));
        end
        if (got.zero_vector !== want.zero_vector) begin
          report_mismatch("zero_vector", 32'(got.zero_vector), 32'(want.zero_vector));
        end
        if (want.zero_vector) zero_vectors_seen++;
      end
      beats_seen++;
    end
  end

  task automatic test_directed_extremes();
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h7FFF, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'hFFFF);
    send_sample(16'h0001, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h0001, 16'hFFFF);
    send_sample(16'h5555, 16'hAAAA, 16'h0F0F);
    send_sample(16'hAAAA, 16'h5555, 16'hF0F0);
    send_sample(16'h0003, 16'h0004, 16'h0000);
  endtask

  task automatic test_sensitivity_settings();
    logic [15:0] settings[5] = '{16'd0, 16'd65535, 16'd573, 16'd1, 16'd3998};
    foreach (settings[i]) begin
      write_sensitivity(settings[i]);
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h7FFF, 16'h8000, 16'h1234);
      repeat (20) send_random_sample();
    end
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < 680; n++) begin
      if (n == 200) drain_results();
      if (n == 250) write_sensitivity(16'($urandom));
      quiet_mode = (n >= 300 && n < 400);
      send_random_sample();
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_sensitivity_settings();
    test_random_stream();
    drain_results();
    $display("Sent %0d samples, checked %0d results, %0d zero vectors, across six sensitivities.",
             beats_sent, beats_seen, zero_vectors_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/svn_pkg.sv
rtl/core/svn_front.sv
rtl/core/svn_step.sv
rtl/core/sensor_vector_scale_normalize_top.sv
bench/tb_top.sv
